@@ rtl/mvcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvcr_pkg: shared definitions for the mains voltage cut/reconnect block
// Register indexes, reset defaults, field widths and the stage structs.
// ----------------------------------------------------------------------------
package mvcr_pkg;

  // Time base width (default for the top-level parameter)
  localparam int TIME_WIDTH_DEF = 32;

  // Field widths
  localparam int NOW_W   = 32;
  localparam int VOLT_W  = 16;
  localparam int LIM_W   = 9;
  localparam int SEC_W   = 12;
  localparam int HYST_W  = 10;
  localparam int DV_W    = 13;   // limit in tenths of a volt, up to 5110
  localparam int MS_W    = 22;   // span in ms, up to 4095000
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 12;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DELAY      = 3'd2;
  localparam logic [IDX_W-1:0] REG_HYST       = 3'd3;
  localparam logic [IDX_W-1:0] REG_STABLE     = 3'd4;

  // Reset defaults (the limit and delay defaults are also the fallback values)
  localparam logic [LIM_W-1:0]  DEF_LOW_V    = 9'd190;
  localparam logic [LIM_W-1:0]  DEF_HIGH_V   = 9'd250;
  localparam logic [SEC_W-1:0]  DEF_DELAY_S  = 12'd180;
  localparam logic [HYST_W-1:0] DEF_HYST_DV  = 10'd50;
  localparam logic [SEC_W-1:0]  DEF_STABLE_S = 12'd10;

  // Readings at or below 1.0 V are treated as a sensor fault
  localparam logic [VOLT_W-1:0] MIN_VALID_DV = 16'd10;

  // Seconds to milliseconds
  localparam logic [MS_W-1:0] MS_PER_S = 22'd1000;

  // Round-up divide by 1000: floor((r + 999) * RECIP / 2^SHIFT), exact below 2^23
  localparam int               DIV_X_W   = MS_W + 1;
  localparam int               DIV_R_W   = 24;
  localparam int               DIV_SHIFT = 33;
  localparam logic [DIV_X_W-1:0] ROUND_UP = 23'd999;
  localparam logic [DIV_R_W-1:0] DIV_RECIP = 24'd8589935;

  // Effective settings after fallbacks, registered in the config unit
  typedef struct packed {
    logic [DV_W-1:0] lo_dv;
    logic [DV_W-1:0] hi_dv;
    logic [DV_W-1:0] band_lo;
    logic [DV_W-1:0] band_hi;
    logic [MS_W-1:0] delay_ms;
    logic [MS_W-1:0] stable_ms;
  } mvcr_cfg_t;

  // Result of the decision stage, before the seconds conversion
  typedef struct packed {
    logic            relay;
    logic            cut;
    logic [MS_W-1:0] rem_ms;
  } mvcr_mid_t;

endpackage

@@ rtl/mvcr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvcr_if: valid/ready channels of the voltage cut/reconnect block
// Input channel carries one check, output channel carries one result.
// ----------------------------------------------------------------------------
interface mvcr_in_if;
  logic                        valid;
  logic                        ready;
  logic [mvcr_pkg::NOW_W-1:0]  now_ms;
  logic [mvcr_pkg::VOLT_W-1:0] voltage_dv;
  logic                        voltage_valid;

  modport source (output valid, output now_ms, output voltage_dv, output voltage_valid,
                  input ready);
  modport sink   (input valid, input now_ms, input voltage_dv, input voltage_valid,
                  output ready);
endinterface

interface mvcr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       relay_closed;
  logic                       in_cut;
  logic [mvcr_pkg::SEC_W-1:0] remaining_s;

  modport source (output valid, output relay_closed, output in_cut, output remaining_s,
                  input ready);
  modport sink   (input valid, input relay_closed, input in_cut, input remaining_s,
                  output ready);
endinterface

@@ rtl/mvcr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvcr_cfg: configuration registers and effective settings
// Holds the five registers and registers the limits, band and spans after
// the fallback rules are applied.
// ----------------------------------------------------------------------------
module mvcr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mvcr_pkg::IDX_W-1:0]    cfg_index,
  input  logic [mvcr_pkg::DATA_W-1:0]   cfg_data,
  output mvcr_pkg::mvcr_cfg_t           eff
);

  logic [mvcr_pkg::LIM_W-1:0]  low_limit_v;
  logic [mvcr_pkg::LIM_W-1:0]  high_limit_v;
  logic [mvcr_pkg::SEC_W-1:0]  reconnect_delay_s;
  logic [mvcr_pkg::HYST_W-1:0] hysteresis_dv;
  logic [mvcr_pkg::SEC_W-1:0]  stable_window_s;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit_v       <= mvcr_pkg::DEF_LOW_V;
      high_limit_v      <= mvcr_pkg::DEF_HIGH_V;
      reconnect_delay_s <= mvcr_pkg::DEF_DELAY_S;
      hysteresis_dv     <= mvcr_pkg::DEF_HYST_DV;
      stable_window_s   <= mvcr_pkg::DEF_STABLE_S;
    end else if (cfg_write) begin
      case (cfg_index)
        mvcr_pkg::REG_LOW_LIMIT:  low_limit_v       <= cfg_data[mvcr_pkg::LIM_W-1:0];
        mvcr_pkg::REG_HIGH_LIMIT: high_limit_v      <= cfg_data[mvcr_pkg::LIM_W-1:0];
        mvcr_pkg::REG_DELAY:      reconnect_delay_s <= cfg_data;
        mvcr_pkg::REG_HYST:       hysteresis_dv     <= cfg_data[mvcr_pkg::HYST_W-1:0];
        mvcr_pkg::REG_STABLE:     stable_window_s   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Fallbacks and derived values
  logic [mvcr_pkg::LIM_W-1:0]  lo_v, hi_v;
  logic [mvcr_pkg::SEC_W-1:0]  dly_s;
  logic [mvcr_pkg::DV_W-1:0]   lo_dv, hi_dv, hyst13;
  logic [mvcr_pkg::DV_W+1:0]   narrow_sum;
  logic                        collapsed;
  mvcr_pkg::mvcr_cfg_t         eff_next;

  always_comb begin
    if (low_limit_v == '0 || high_limit_v == '0 || low_limit_v >= high_limit_v) begin
      lo_v = mvcr_pkg::DEF_LOW_V;
      hi_v = mvcr_pkg::DEF_HIGH_V;
    end else begin
      lo_v = low_limit_v;
      hi_v = high_limit_v;
    end
    dly_s = (reconnect_delay_s == '0) ? mvcr_pkg::DEF_DELAY_S : reconnect_delay_s;

    // x10 as x8 + x2
    lo_dv  = (mvcr_pkg::DV_W'(lo_v) << 3) + (mvcr_pkg::DV_W'(lo_v) << 1);
    hi_dv  = (mvcr_pkg::DV_W'(hi_v) << 3) + (mvcr_pkg::DV_W'(hi_v) << 1);
    hyst13 = mvcr_pkg::DV_W'(hysteresis_dv);

    // Narrowed band is empty when lo + 2*hyst >= hi
    narrow_sum = (mvcr_pkg::DV_W+2)'(lo_dv) + ((mvcr_pkg::DV_W+2)'(hyst13) << 1);
    collapsed  = narrow_sum >= (mvcr_pkg::DV_W+2)'(hi_dv);

    eff_next.lo_dv     = lo_dv;
    eff_next.hi_dv     = hi_dv;
    eff_next.band_lo   = collapsed ? lo_dv : lo_dv + hyst13;
    eff_next.band_hi   = collapsed ? hi_dv : hi_dv - hyst13;
    eff_next.delay_ms  = mvcr_pkg::MS_W'(dly_s) * mvcr_pkg::MS_PER_S;
    eff_next.stable_ms = mvcr_pkg::MS_W'(stable_window_s) * mvcr_pkg::MS_PER_S;
  end

  always_ff @(posedge clk) begin
    eff <= eff_next;
  end

endmodule

@@ rtl/mvcr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvcr_core: cut/reconnect decision and protection state
// Classifies the reading, runs the two timers, updates the latched state
// and registers relay, cut and the remaining time in ms.
// ----------------------------------------------------------------------------
module mvcr_core #(
  parameter int TIME_WIDTH = mvcr_pkg::TIME_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,        // item moves into mid register
  input  logic [mvcr_pkg::NOW_W-1:0]    now_ms,
  input  logic [mvcr_pkg::VOLT_W-1:0]   voltage_dv,
  input  logic                          voltage_valid,
  input  mvcr_pkg::mvcr_cfg_t           eff,
  output mvcr_pkg::mvcr_mid_t           mid
);

  localparam int CW = (TIME_WIDTH > mvcr_pkg::MS_W) ? TIME_WIDTH : mvcr_pkg::MS_W;

  logic                  cut_latched, delay_running, stable_running, relay_drive;
  logic [TIME_WIDTH-1:0] delay_start, stable_mark;

  logic                  cut_next, dr_next, sr_next, relay_next;
  logic [TIME_WIDTH-1:0] ds_next, ss_next;

  logic [TIME_WIDTH-1:0]   now_t, ds_eff, ss_eff, el_d, el_s;
  logic [CW-1:0]           el_d_x, el_s_x, dspan_x, sspan_x, rd_x, rs_x;
  logic [mvcr_pkg::MS_W-1:0] rd, rs, rem;
  logic                    valid, trip, in_band, exp_d, exp_s;
  logic [mvcr_pkg::VOLT_W-1:0] lo_v, hi_v, blo_v, bhi_v;

  // Classification and timers
  always_comb begin
    now_t = TIME_WIDTH'(now_ms);
    lo_v  = mvcr_pkg::VOLT_W'(eff.lo_dv);
    hi_v  = mvcr_pkg::VOLT_W'(eff.hi_dv);
    blo_v = mvcr_pkg::VOLT_W'(eff.band_lo);
    bhi_v = mvcr_pkg::VOLT_W'(eff.band_hi);

    valid    = voltage_valid && (voltage_dv > mvcr_pkg::MIN_VALID_DV);
    trip     = !valid || voltage_dv < lo_v || voltage_dv > hi_v;
    in_band  = voltage_dv >= blo_v && voltage_dv <= bhi_v;

    // A timer that is not running starts at this check
    ds_eff = delay_running  ? delay_start : now_t;
    ss_eff = stable_running ? stable_mark : now_t;
    el_d   = now_t - ds_eff;
    el_s   = now_t - ss_eff;

    el_d_x  = CW'(el_d);
    el_s_x  = CW'(el_s);
    dspan_x = CW'(eff.delay_ms);
    sspan_x = CW'(eff.stable_ms);
    exp_d   = el_d_x >= dspan_x;
    exp_s   = el_s_x >= sspan_x;
    rd_x    = dspan_x - el_d_x;
    rs_x    = sspan_x - el_s_x;
    rd      = exp_d ? '0 : rd_x[mvcr_pkg::MS_W-1:0];
    rs      = exp_s ? '0 : rs_x[mvcr_pkg::MS_W-1:0];

    // State update
    cut_next   = cut_latched;
    dr_next    = delay_running;
    sr_next    = stable_running;
    relay_next = relay_drive;
    ds_next    = delay_start;
    ss_next    = stable_mark;
    rem        = '0;
    if (trip) begin
      cut_next   = 1'b1;
      dr_next    = 1'b0;
      sr_next    = 1'b0;
      relay_next = 1'b0;
    end else if (cut_latched) begin
      if (in_band) begin
        ds_next = ds_eff;
        ss_next = ss_eff;
        dr_next = 1'b1;
        sr_next = 1'b1;
        rem     = (rd > rs) ? rd : rs;
        if (exp_d && exp_s) begin
          relay_next = 1'b1;
          cut_next   = 1'b0;
          dr_next    = 1'b0;
          sr_next    = 1'b0;
        end
      end else begin
        dr_next = 1'b0;
        sr_next = 1'b0;
      end
    end else begin
      relay_next = 1'b1;
    end
  end

  // Protection state
  always_ff @(posedge clk) begin
    if (rst) begin
      cut_latched    <= 1'b1;
      delay_running  <= 1'b0;
      stable_running <= 1'b0;
      relay_drive    <= 1'b0;
    end else if (fire) begin
      cut_latched    <= cut_next;
      delay_running  <= dr_next;
      stable_running <= sr_next;
      relay_drive    <= relay_next;
    end
  end

  // Timer start stamps and mid register
  always_ff @(posedge clk) begin
    if (fire) begin
      delay_start  <= ds_next;
      stable_mark  <= ss_next;
      mid.relay    <= relay_next;
      mid.cut      <= cut_next;
      mid.rem_ms   <= rem;
    end
  end

  // Relay closed and cut latched exclude each other
  a_relay_cut_excl: assert property (@(posedge clk) disable iff (rst)
    !(relay_drive && cut_latched))
    else $error("relay closed while cut latched");

  // Timers run only while cut
  a_timer_in_cut: assert property (@(posedge clk) disable iff (rst)
    (delay_running || stable_running) |-> cut_latched)
    else $error("timer running outside cut");

  // A bad or out-of-limit reading always opens the relay
  a_cut_opens: assert property (@(posedge clk) disable iff (rst)
    (fire && trip) |=> (!relay_drive && cut_latched && !delay_running))
    else $error("cut did not open relay");

endmodule

@@ rtl/mvcr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvcr_div: remaining-time conversion and result register
// Converts remaining ms to whole seconds rounded up by a reciprocal
// multiply and holds the finished result.
// ----------------------------------------------------------------------------
module mvcr_div (
  input  logic                        clk,
  input  logic                        load,
  input  mvcr_pkg::mvcr_mid_t         mid,
  output logic                        relay_closed,
  output logic                        in_cut,
  output logic [mvcr_pkg::SEC_W-1:0]  remaining_s
);

  localparam int PROD_W = mvcr_pkg::DIV_X_W + mvcr_pkg::DIV_R_W;

  logic [mvcr_pkg::DIV_X_W-1:0] x;
  logic [PROD_W-1:0]            prod;
  logic [PROD_W-1:0]            quot;

  // ceil(r / 1000) = floor((r + 999) / 1000)
  always_comb begin
    x    = mvcr_pkg::DIV_X_W'(mid.rem_ms) + mvcr_pkg::ROUND_UP;
    prod = PROD_W'(x) * PROD_W'(mvcr_pkg::DIV_RECIP);
    quot = prod >> mvcr_pkg::DIV_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      relay_closed <= mid.relay;
      in_cut       <= mid.cut;
      remaining_s  <= quot[mvcr_pkg::SEC_W-1:0];
    end
  end

endmodule

@@ rtl/mains_voltage_cut_reconnect_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_voltage_cut_reconnect_top: over/under-voltage relay protector
// Cuts the relay on bad or out-of-limit readings and reconnects after the
// reconnect delay and stability window have both run in band.
// ----------------------------------------------------------------------------
//  channel   direction  handshake    payload
//  in_ch     in         valid/ready  now_ms, voltage_dv, voltage_valid
//  out_ch    out        valid/ready  relay_closed, in_cut, remaining_s
//  cfg       in         cfg_write    cfg_index, cfg_data
//
//  One item per cycle while the result side keeps taking results; each item
//  passes the input register, the decision stage and the seconds conversion
//  stage in order. The rate is set by the protection state update in the
//  decision stage, which finishes each item before the next one enters.
//  Reset: relay open, cut latched, registers at defaults; no clearing pass.
//  A stalled result holds the pipeline; outside reset, ready drops only while
//  all three stages are full and the result is held.
// ----------------------------------------------------------------------------
module mains_voltage_cut_reconnect_top #(
  parameter int TIME_WIDTH = mvcr_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  mvcr_in_if.sink                     in_ch,
  mvcr_out_if.source                  out_ch,
  input  logic                        cfg_write,
  input  logic [mvcr_pkg::IDX_W-1:0]  cfg_index,
  input  logic [mvcr_pkg::DATA_W-1:0] cfg_data
);

  logic s1_valid, mid_valid, out_valid;
  logic en_in, en_mid, en_out;

  logic [mvcr_pkg::NOW_W-1:0]  s1_now;
  logic [mvcr_pkg::VOLT_W-1:0] s1_volt;
  logic                        s1_vok;

  mvcr_pkg::mvcr_cfg_t eff;
  mvcr_pkg::mvcr_mid_t mid;

  // Stage enables: a register loads when its downstream can take it
  assign en_out      = !out_valid || out_ch.ready;
  assign en_mid      = !mid_valid || en_out;
  assign en_in       = !s1_valid || en_mid;
  assign in_ch.ready = en_in && !rst;
  assign out_ch.valid = out_valid;

  // Stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_in)  s1_valid  <= in_ch.valid;
      if (en_mid) mid_valid <= s1_valid;
      if (en_out) out_valid <= mid_valid;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (en_in && in_ch.valid) begin
      s1_now  <= in_ch.now_ms;
      s1_volt <= in_ch.voltage_dv;
      s1_vok  <= in_ch.voltage_valid;
    end
  end

  mvcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff       (eff)
  );

  mvcr_core #(.TIME_WIDTH(TIME_WIDTH)) u_core (
    .clk           (clk),
    .rst           (rst),
    .fire          (s1_valid && en_mid),
    .now_ms        (s1_now),
    .voltage_dv    (s1_volt),
    .voltage_valid (s1_vok),
    .eff           (eff),
    .mid           (mid)
  );

  mvcr_div u_div (
    .clk          (clk),
    .load         (mid_valid && en_out),
    .mid          (mid),
    .relay_closed (out_ch.relay_closed),
    .in_cut       (out_ch.in_cut),
    .remaining_s  (out_ch.remaining_s)
  );

  // Input stalls only with every stage occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && mid_valid && out_valid))
    else $error("input stalled with a free stage");

  // Time left implies the cut is still latched
  a_rem_in_cut: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ch.remaining_s != '0) |-> (out_ch.in_cut && !out_ch.relay_closed))
    else $error("remaining time outside cut");

endmodule

@@ verif/mains_voltage_cut_reconnect_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mains_voltage_cut_reconnect_top_test: self-checking bench for the relay cutter
// A probe table walks the cut limits, bad readings, band edges and timestamp
// wrap, then phases of random checks run under changing limit, delay,
// hysteresis and stability settings. A model of the protector predicts
// every result that the probe table does not give, and both channels stall at random.
// ----------------------------------------------------------------------------
module mains_voltage_cut_reconnect_top_test;

  localparam int WATCHDOG_LIMIT   = 600;
  localparam int PHASE_COUNT      = 10;
  localparam int CHECKS_PER_PHASE = 125;
  localparam int PROBE_COUNT      = 24;

  typedef struct packed {
    logic                       relay_closed;
    logic                       in_cut;
    logic [mvcr_pkg::SEC_W-1:0] remaining_s;
  } relay_result_t;

  // One probe: reading, and the result where it is obvious
  typedef struct packed {
    logic [mvcr_pkg::NOW_W-1:0]  now_ms;
    logic [mvcr_pkg::VOLT_W-1:0] voltage_dv;
    logic                        voltage_valid;
    logic                        typed;
    relay_result_t               result;
  } probe_t;

  logic clk = 1'b0;
  logic rst;
  logic                        cfg_write;
  logic [mvcr_pkg::IDX_W-1:0]  cfg_index;
  logic [mvcr_pkg::DATA_W-1:0] cfg_data;

  mvcr_in_if  in_ch ();
  mvcr_out_if out_ch ();

  mains_voltage_cut_reconnect_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Settings as the protector holds them
  logic [mvcr_pkg::LIM_W-1:0]  lim_lo_v  = mvcr_pkg::DEF_LOW_V;
  logic [mvcr_pkg::LIM_W-1:0]  lim_hi_v  = mvcr_pkg::DEF_HIGH_V;
  logic [mvcr_pkg::SEC_W-1:0]  delay_s   = mvcr_pkg::DEF_DELAY_S;
  logic [mvcr_pkg::HYST_W-1:0] hyst_dv   = mvcr_pkg::DEF_HYST_DV;
  logic [mvcr_pkg::SEC_W-1:0]  stable_s  = mvcr_pkg::DEF_STABLE_S;

  // Protection state: power-up counts as a cut with the relay open
  logic                       cut_on      = 1'b1;
  logic                       delay_run   = 1'b0;
  logic                       stable_run  = 1'b0;
  logic [mvcr_pkg::NOW_W-1:0] delay_t0    = '0;
  logic [mvcr_pkg::NOW_W-1:0] stable_t0   = '0;
  logic                       relay_drive = 1'b0;

  relay_result_t awaited_results [$];
  int mismatches   = 0;
  int quiet_cycles = 0;
  int source_calm  = 0;
  int sink_calm    = 0;

  // Wait before the next item; runs of zero give stretches with no idling
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  // Limits after fallback, reconnect band and timer spans
  function automatic void effective_band(output int lo_dv, output int hi_dv,
                                         output int band_lo, output int band_hi,
                                         output longint delay_ms, output longint stable_ms);
    logic [mvcr_pkg::LIM_W-1:0] lo;
    logic [mvcr_pkg::LIM_W-1:0] hi;
    lo = lim_lo_v;
    hi = lim_hi_v;
    if (lo == 0 || hi == 0 || lo >= hi) begin
      lo = mvcr_pkg::DEF_LOW_V;
      hi = mvcr_pkg::DEF_HIGH_V;
    end
    lo_dv   = int'(lo) * 10;
    hi_dv   = int'(hi) * 10;
    band_lo = lo_dv + int'(hyst_dv);
    band_hi = hi_dv - int'(hyst_dv);
    // narrowed band empty: reconnect on the cut band itself
    if (band_lo >= band_hi) begin
      band_lo = lo_dv;
      band_hi = hi_dv;
    end
    delay_ms  = longint'((delay_s == 0) ? mvcr_pkg::DEF_DELAY_S : delay_s) * 1000;
    stable_ms = longint'(stable_s) * 1000;
  endfunction

  // One periodic check through the protector
  function automatic relay_result_t predict_check(logic [mvcr_pkg::NOW_W-1:0] now,
                                                  logic [mvcr_pkg::VOLT_W-1:0] volt,
                                                  logic ok);
    int lo_dv, hi_dv, band_lo, band_hi, v;
    longint delay_ms, stable_ms, left_d, left_s, left_ms;
    logic [mvcr_pkg::NOW_W-1:0] el_d, el_s;
    relay_result_t res;
    effective_band(lo_dv, hi_dv, band_lo, band_hi, delay_ms, stable_ms);
    v = int'(volt);
    res.remaining_s = '0;
    if (!ok || v <= int'(mvcr_pkg::MIN_VALID_DV) || v < lo_dv || v > hi_dv) begin
      cut_on      = 1'b1;
      delay_run   = 1'b0;
      stable_run  = 1'b0;
      relay_drive = 1'b0;
    end else if (cut_on) begin
      if (v >= band_lo && v <= band_hi) begin
        if (!delay_run) begin
          delay_t0  = now;
          delay_run = 1'b1;
        end
        if (!stable_run) begin
          stable_t0  = now;
          stable_run = 1'b1;
        end
        // elapsed time wraps with the timestamp
        el_d = now - delay_t0;
        el_s = now - stable_t0;
        left_d  = (longint'(el_d) >= delay_ms)  ? 0 : delay_ms - longint'(el_d);
        left_s  = (longint'(el_s) >= stable_ms) ? 0 : stable_ms - longint'(el_s);
        left_ms = (left_d > left_s) ? left_d : left_s;
        res.remaining_s = mvcr_pkg::SEC_W'((left_ms + 999) / 1000);
        if (left_ms == 0) begin
          relay_drive = 1'b1;
          cut_on      = 1'b0;
          delay_run   = 1'b0;
          stable_run  = 1'b0;
        end
      end else begin
        // between bands while cut: timers stop
        delay_run  = 1'b0;
        stable_run = 1'b0;
      end
    end else if (!relay_drive) begin
      relay_drive = 1'b1;
    end
    res.relay_closed = relay_drive;
    res.in_cut       = cut_on;
    return res;
  endfunction

  // Offer one check, record its expected result once accepted
  task automatic send_check(logic [mvcr_pkg::NOW_W-1:0] now,
                            logic [mvcr_pkg::VOLT_W-1:0] volt, logic ok,
                            logic typed, relay_result_t typed_res);
    int gap;
    relay_result_t predicted;
    gap = draw_wait(source_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.now_ms        <= now;
    in_ch.voltage_dv    <= volt;
    in_ch.voltage_valid <= ok;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_check(now, volt, ok);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [mvcr_pkg::IDX_W-1:0] idx,
                           logic [mvcr_pkg::DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      mvcr_pkg::REG_LOW_LIMIT:  lim_lo_v = data[mvcr_pkg::LIM_W-1:0];
      mvcr_pkg::REG_HIGH_LIMIT: lim_hi_v = data[mvcr_pkg::LIM_W-1:0];
      mvcr_pkg::REG_DELAY:      delay_s  = data[mvcr_pkg::SEC_W-1:0];
      mvcr_pkg::REG_HYST:       hyst_dv  = data[mvcr_pkg::HYST_W-1:0];
      mvcr_pkg::REG_STABLE:     stable_s = data[mvcr_pkg::SEC_W-1:0];
      default: ;
    endcase
  endtask

  // Settings change only with the pipeline empty
  task automatic apply_settings(int lo, int hi, int dly, int hyst, int stb);
    drain_results();
    repeat (4) @(posedge clk);
    write_reg(mvcr_pkg::REG_LOW_LIMIT,  mvcr_pkg::DATA_W'(lo));
    write_reg(mvcr_pkg::REG_HIGH_LIMIT, mvcr_pkg::DATA_W'(hi));
    write_reg(mvcr_pkg::REG_DELAY,      mvcr_pkg::DATA_W'(dly));
    write_reg(mvcr_pkg::REG_HYST,       mvcr_pkg::DATA_W'(hyst));
    write_reg(mvcr_pkg::REG_STABLE,     mvcr_pkg::DATA_W'(stb));
    cfg_write <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Defaults: cut below 1900 or above 2500 dV, reconnect band 1950..2450,
  // 180 s delay, 10 s stability window
  probe_t probe_rows [0:PROBE_COUNT-1] = '{
    '{32'd0,          16'd2300,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd180}},
    '{32'd1,          16'd2300,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd180}},
    '{32'd1000,       16'd2300,  1'b1, 1'b0, '{1'b0, 1'b0, 12'd0}},
    '{32'd179001,     16'd2300,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd1}},
    '{32'd180000,     16'd2300,  1'b1, 1'b1, '{1'b1, 1'b0, 12'd0}},
    '{32'd181000,     16'd2500,  1'b1, 1'b1, '{1'b1, 1'b0, 12'd0}},
    '{32'd182000,     16'd2501,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd183000,     16'd1900,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd184000,     16'd1899,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd185000,     16'hFFFF,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd186000,     16'd2300,  1'b0, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd187000,     16'd10,    1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd188000,     16'd11,    1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd189000,     16'd0,     1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd200000,     16'd1950,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd180}},
    '{32'd205000,     16'd2450,  1'b1, 1'b0, '{1'b0, 1'b0, 12'd0}},
    '{32'd206000,     16'd2451,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'd207000,     16'd2400,  1'b1, 1'b0, '{1'b0, 1'b0, 12'd0}},
    '{32'hFFFF_0000,  16'd0,     1'b1, 1'b1, '{1'b0, 1'b1, 12'd0}},
    '{32'hFFFF_FC18,  16'd2200,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd180}},
    '{32'h0002_BB37,  16'd2200,  1'b1, 1'b1, '{1'b0, 1'b1, 12'd1}},
    '{32'h0002_BB38,  16'd2200,  1'b1, 1'b1, '{1'b1, 1'b0, 12'd0}},
    '{32'h0002_C000,  16'd1920,  1'b1, 1'b1, '{1'b1, 1'b0, 12'd0}},
    '{32'hFFFF_FFFF,  16'd2200,  1'b0, 1'b1, '{1'b0, 1'b1, 12'd0}}
  };

  // Stimulus: probes, then random phases
  initial begin : stimulus
    int lo, hi, dly, hyst, stb, pick;
    int lo_dv, hi_dv, band_lo, band_hi;
    longint delay_ms, stable_ms, span;
    logic [mvcr_pkg::NOW_W-1:0]  clock_ms;
    logic [mvcr_pkg::VOLT_W-1:0] volt;
    logic                        ok;
    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.now_ms        <= '0;
    in_ch.voltage_dv    <= '0;
    in_ch.voltage_valid <= 1'b0;
    cfg_write           <= 1'b0;
    cfg_index           <= mvcr_pkg::REG_LOW_LIMIT;
    cfg_data            <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PROBE_COUNT; i++) begin
      send_check(probe_rows[i].now_ms, probe_rows[i].voltage_dv, probe_rows[i].voltage_valid,
                 probe_rows[i].typed, probe_rows[i].result);
    end

    clock_ms = $urandom;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        // zero stability window, one second delay
        0: apply_settings(190, 250, 1, 50, 0);
        // zero low limit and zero delay fall back; longest window
        1: apply_settings(0, 500, 0, 0, 3600);
        // widest limits, longest delay, widest hysteresis
        2: apply_settings(1, 500, 3600, 1000, 1);
        // equal limits fall back, band collapses
        3: apply_settings(250, 250, 2, 1000, 2);
        // narrowed band just empty
        4: apply_settings(499, 500, 1, 5, 1);
        // low above high falls back
        5: apply_settings(300, 200, 5, 1, 0);
        default: begin
          lo   = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 499);
          hi   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 500)
                                             : $urandom_range(lo + 1, 500);
          pick = $urandom_range(0, 7);
          dly  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 3600)
                                                : $urandom_range(1, 20);
          hyst = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1000)
                                             : $urandom_range(0, 100);
          pick = $urandom_range(0, 7);
          stb  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 3600)
                                                : $urandom_range(0, 20);
          apply_settings(lo, hi, dly, hyst, stb);
        end
      endcase
      effective_band(lo_dv, hi_dv, band_lo, band_hi, delay_ms, stable_ms);
      span = (delay_ms > stable_ms) ? delay_ms : stable_ms;

      for (int k = 0; k < CHECKS_PER_PHASE; k++) begin
        // time advance: mostly fractions of the timer span, now and then a jump
        pick = $urandom_range(0, 99);
        if (pick < 10)
          clock_ms = clock_ms;
        else if (pick < 55)
          clock_ms = clock_ms + $urandom_range(0, 32'(span / 8 + 1));
        else if (pick < 93)
          clock_ms = clock_ms + $urandom_range(0, 32'(span / 2 + 1));
        else
          clock_ms = $urandom;

        // reading: mostly in the reconnect band, the rest disturbs it
        ok   = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          volt = mvcr_pkg::VOLT_W'($urandom_range(band_lo, band_hi));
        end else if (pick < 86) begin
          volt = mvcr_pkg::VOLT_W'($urandom_range(lo_dv, hi_dv));
        end else if (pick < 93) begin
          case ($urandom_range(0, 9))
            0: volt = mvcr_pkg::VOLT_W'(lo_dv);
            1: volt = mvcr_pkg::VOLT_W'(hi_dv);
            2: volt = mvcr_pkg::VOLT_W'(lo_dv - 1);
            3: volt = mvcr_pkg::VOLT_W'(hi_dv + 1);
            4: volt = mvcr_pkg::VOLT_W'(band_lo);
            5: volt = mvcr_pkg::VOLT_W'(band_hi);
            6: volt = mvcr_pkg::VOLT_W'(band_lo - 1);
            7: volt = mvcr_pkg::VOLT_W'(band_hi + 1);
            8: volt = mvcr_pkg::MIN_VALID_DV;
            default: volt = mvcr_pkg::MIN_VALID_DV + 16'd1;
          endcase
        end else if (pick < 97) begin
          volt = mvcr_pkg::VOLT_W'($urandom);
          ok   = 1'($urandom_range(0, 1));
        end else begin
          volt = mvcr_pkg::VOLT_W'($urandom_range(band_lo, band_hi));
          ok   = 1'b0;
        end
        send_check(clock_ms, volt, ok, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Result side: random back-pressure, field-by-field compare
  initial begin : result_sink
    int gap;
    relay_result_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_wait(sink_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (awaited_results.size() == 0) begin
        $error("result item with no check pending: relay_closed %0d in_cut %0d remaining_s %0d",
               out_ch.relay_closed, out_ch.in_cut, out_ch.remaining_s);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.relay_closed !== want.relay_closed) begin
          $error("relay_closed: expected %0d, got %0d", want.relay_closed, out_ch.relay_closed);
          mismatches++;
        end
        if (out_ch.in_cut !== want.in_cut) begin
          $error("in_cut: expected %0d, got %0d", want.in_cut, out_ch.in_cut);
          mismatches++;
        end
        if (out_ch.remaining_s !== want.remaining_s) begin
          $error("remaining_s: expected %0d, got %0d", want.remaining_s, out_ch.remaining_s);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

@@ mains_voltage_cut_reconnect_top.f @@
rtl/mvcr_pkg.sv
rtl/mvcr_if.sv
rtl/mvcr_cfg.sv
rtl/mvcr_core.sv
rtl/mvcr_div.sv
rtl/mains_voltage_cut_reconnect_top.sv
verif/mains_voltage_cut_reconnect_top_test.sv
